[hw/rtl/rlfe_pkg.sv]
// Shared types, codes and frame constants of the radar link frame engine.
package rlfe_pkg;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ARM  = 2'd1;
    localparam logic [1:0] CMD_RX   = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    localparam logic [2:0] KIND_TX           = 3'd0;
    localparam logic [2:0] KIND_ACK_DONE     = 3'd1;
    localparam logic [2:0] KIND_ACK_TIMEOUT  = 3'd2;
    localparam logic [2:0] KIND_DATA_VALUE   = 3'd3;
    localparam logic [2:0] KIND_DATA_TIMEOUT = 3'd4;

    localparam logic [16:0] TICK_MAX = 17'h1FFFF;

    localparam logic [3:0] LAST_IDX_SHORT = 4'd11;
    localparam logic [3:0] LAST_IDX_LONG  = 4'd13;

    localparam logic [7:0] ACK_HEAD [4]  = '{8'hfd, 8'hfc, 8'hfb, 8'hfa};
    localparam logic [7:0] DATA_HEAD [4] = '{8'hf4, 8'hf3, 8'hf2, 8'hf1};
    localparam logic [7:0] FOOTER [4]    = '{8'h04, 8'h03, 8'h02, 8'h01};

    typedef enum logic [1:0] {
        W_IDLE = 2'd0,
        W_ACK  = 2'd1,
        W_DATA = 2'd2
    } t_wait_mode;

    typedef struct packed {
        logic        is_send;
        logic [2:0]  kind;
        logic [7:0]  ack_length;
        logic [31:0] raw_value;
        logic [7:0]  command_code;
        logic        has_argument;
        logic [15:0] argument;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Byte idx of an outgoing command frame; short frames skip the argument bytes.
    function automatic logic [7:0] f_frame_byte(logic [3:0] idx, logic longf,
                                                logic [7:0] code, logic [15:0] arg);
        logic [3:0] p;
        logic [7:0] b;
        p = (!longf && idx >= 4'd8) ? idx + 4'd2 : idx;
        case (p)
            4'd0:    b = ACK_HEAD[0];
            4'd1:    b = ACK_HEAD[1];
            4'd2:    b = ACK_HEAD[2];
            4'd3:    b = ACK_HEAD[3];
            4'd4:    b = longf ? 8'd4 : 8'd2;
            4'd6:    b = code;
            4'd8:    b = arg[7:0];
            4'd9:    b = arg[15:8];
            4'd10:   b = FOOTER[0];
            4'd11:   b = FOOTER[1];
            4'd12:   b = FOOTER[2];
            4'd13:   b = FOOTER[3];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/rlfe_front.sv]
// Front end: accepts transactions, runs wait state, matchers and timeout, queues results.
module rlfe_front import rlfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_accept,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_command_code,
    input  logic        i_has_argument,
    input  logic [15:0] i_argument,
    input  logic [7:0]  i_rx_byte,
    output logic        o_push,
    output t_entry      o_entry
);

    t_wait_mode  r_mode, n_mode;
    logic [8:0]  r_pos, n_pos;
    logic [7:0]  r_len, n_len;
    logic [23:0] r_vbytes, n_vbytes;
    logic [16:0] r_elapsed, n_elapsed;
    logic        r_seen, n_seen;
    logic [15:0] r_timeout;

    logic [16:0] tick_inc;
    logic        live;
    logic [8:0]  ack_end;
    logic [4:0]  vshift;

    assign tick_inc = (r_elapsed != TICK_MAX) ? r_elapsed + 17'd1 : r_elapsed;
    assign live     = (r_mode == W_ACK) || (r_mode == W_DATA && !r_seen);
    assign ack_end  = {1'b0, r_len} + 9'd6;
    assign vshift   = {r_pos[1:0] - 2'd2, 3'b000};

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_len     = r_len;
        n_vbytes  = r_vbytes;
        n_elapsed = r_elapsed;
        n_seen    = r_seen;
        if (i_accept) begin
            unique case (i_cmd) inside
                CMD_SEND, CMD_ARM: begin
                    n_mode    = (i_cmd == CMD_SEND) ? W_ACK : W_DATA;
                    n_pos     = '0;
                    n_len     = '0;
                    n_vbytes  = '0;
                    n_elapsed = '0;
                    n_seen    = 1'b0;
                end
                CMD_RX: begin
                    if (r_mode == W_ACK) begin
                        if (r_pos < 9'd4) begin
                            n_pos = (i_rx_byte == ACK_HEAD[r_pos[1:0]]) ? r_pos + 9'd1 : '0;
                        end else if (r_pos == 9'd4) begin
                            n_len = i_rx_byte;
                            n_pos = 9'd5;
                        end else if (r_pos < ack_end) begin
                            n_pos = r_pos + 9'd1;
                        end else begin
                            n_mode    = W_IDLE;
                            n_pos     = '0;
                            n_len     = '0;
                            n_vbytes  = '0;
                            n_elapsed = '0;
                            n_seen    = 1'b0;
                        end
                    end else if (r_mode == W_DATA) begin
                        if (r_pos < 9'd4) begin
                            n_pos = (i_rx_byte == DATA_HEAD[r_pos[1:0]]) ? r_pos + 9'd1 : '0;
                        end else if (r_pos == 9'd4) begin
                            n_len = i_rx_byte;
                            n_pos = 9'd5;
                        end else if (r_pos == 9'd5) begin
                            n_pos = 9'd6;
                        end else if (r_pos < 9'd9) begin
                            n_vbytes = r_vbytes | ({16'h0, i_rx_byte} << vshift);
                            n_pos    = r_pos + 9'd1;
                        end else begin
                            n_vbytes = '0;
                            n_pos    = '0;
                            n_seen   = 1'b1;
                        end
                    end
                end
                CMD_TICK: begin
                    if (live && r_timeout != 16'd0) begin
                        n_elapsed = tick_inc;
                        if (tick_inc > {1'b0, r_timeout}) begin
                            n_mode    = W_IDLE;
                            n_pos     = '0;
                            n_len     = '0;
                            n_vbytes  = '0;
                            n_elapsed = '0;
                            n_seen    = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_push                = 1'b0;
        o_entry               = '0;
        o_entry.command_code  = i_command_code;
        o_entry.has_argument  = i_has_argument;
        o_entry.argument      = i_argument;
        if (i_accept) begin
            unique case (i_cmd)
                CMD_SEND: begin
                    o_push          = 1'b1;
                    o_entry.is_send = 1'b1;
                    o_entry.kind    = KIND_TX;
                end
                CMD_RX: begin
                    if (r_mode == W_ACK && r_pos > 9'd4 && r_pos >= ack_end) begin
                        o_push             = 1'b1;
                        o_entry.kind       = KIND_ACK_DONE;
                        o_entry.ack_length = r_len;
                    end else if (r_mode == W_DATA && r_pos == 9'd9) begin
                        o_push            = 1'b1;
                        o_entry.kind      = KIND_DATA_VALUE;
                        o_entry.raw_value = {i_rx_byte, r_vbytes};
                    end
                end
                CMD_TICK: begin
                    if (live && r_timeout != 16'd0 && tick_inc > {1'b0, r_timeout}) begin
                        o_push       = 1'b1;
                        o_entry.kind = (r_mode == W_ACK) ? KIND_ACK_TIMEOUT : KIND_DATA_TIMEOUT;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= W_IDLE;
            r_pos     <= '0;
            r_len     <= '0;
            r_vbytes  <= '0;
            r_elapsed <= '0;
            r_seen    <= 1'b0;
            r_timeout <= '0;
        end else begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_vbytes  <= n_vbytes;
            r_elapsed <= n_elapsed;
            r_seen    <= n_seen;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

endmodule

[hw/rtl/rlfe_fifo.sv]
// Short queue of pending result entries between front and back end.
module rlfe_fifo import rlfe_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_entry     i_entry,
    input  logic       i_pop,
    output t_entry     o_entry,
    output t_fifo_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_cnt == CNT_FULL);
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_entry      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[hw/rtl/rlfe_back.sv]
// Back end: expands queued entries into result transactions through an output register.
module rlfe_back import rlfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_entry,
    input  t_fifo_stat  i_stat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [7:0]  o_ack_length,
    output logic [31:0] o_raw_value,
    output logic        o_last
);

    t_entry      r_ent;
    logic        r_busy;
    logic [3:0]  r_idx;
    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [7:0]  r_tx_byte;
    logic [7:0]  r_ack_length;
    logic [31:0] r_raw_value;
    logic        r_last;

    logic        can_load, emit, final_res;

    assign can_load  = !r_out_valid || i_ready;
    assign emit      = r_busy && can_load;
    assign final_res = !r_ent.is_send ||
                       (r_idx == (r_ent.has_argument ? LAST_IDX_LONG : LAST_IDX_SHORT));
    assign o_pop     = !i_stat.empty && (!r_busy || (emit && final_res));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
        if (emit) begin
            r_kind       <= r_ent.kind;
            r_tx_byte    <= r_ent.is_send ?
                            f_frame_byte(r_idx, r_ent.has_argument,
                                         r_ent.command_code, r_ent.argument) : 8'h00;
            r_ack_length <= r_ent.ack_length;
            r_raw_value  <= r_ent.raw_value;
            r_last       <= final_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 4'd1;
                if (final_res) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_tx_byte    = r_tx_byte;
    assign o_ack_length = r_ack_length;
    assign o_raw_value  = r_raw_value;
    assign o_last       = r_last;

endmodule

[hw/rtl/radar_link_frame_engine_core.sv]
// Top level of the radar link frame engine: front end, result queue, back end.
// Path: result queue, back-end entry register, back-end output register.
// Throughput: one input transaction per cycle while the result queue has room;
// the back end's output register delivers one result per cycle unless i_ready
// stalls it; a send yields 12 (short) or 14 (long) results, other items one.
// Reset: synchronous, active low; clears the wait, timeout register and queue.
module radar_link_frame_engine_core import rlfe_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_command_code,
    input  logic        i_has_argument,
    input  logic [15:0] i_argument,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [7:0]  o_ack_length,
    output logic [31:0] o_raw_value,
    output logic        o_last
);

    logic       accept, push, pop;
    t_entry     push_entry, head_entry;
    t_fifo_stat fifo_stat;

    assign o_ready = !fifo_stat.full;
    assign accept  = i_valid && o_ready;

    rlfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_cmd          (i_cmd),
        .i_command_code (i_command_code),
        .i_has_argument (i_has_argument),
        .i_argument     (i_argument),
        .i_rx_byte      (i_rx_byte),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    rlfe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (fifo_stat)
    );

    rlfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (head_entry),
        .i_stat       (fifo_stat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_tx_byte    (o_tx_byte),
        .o_ack_length (o_ack_length),
        .o_raw_value  (o_raw_value),
        .o_last       (o_last)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !fifo_stat.full)
        else $error("result entry pushed into full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fifo_stat.empty)
        else $error("pop from empty queue");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_TX) |-> o_last)
        else $error("status result without last flag");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_TX) |-> (o_tx_byte == 8'h00))
        else $error("status result carries a transmit byte");
`endif

endmodule
